/* rtl/core/prvc_pkg.sv */
// ----------------------------------------------------------------------------
// prvc_pkg
// Shared widths, codes and defaults of the photometric correction block.
// ----------------------------------------------------------------------------
package prvc_pkg;

   // payload widths
   localparam int KIND_W      = 2;
   localparam int INDEX_W     = 19;
   localparam int SAMPLE_W    = 17;
   localparam int ENTRY_W     = 16;
   localparam int RESULT_W    = 24;
   localparam int REQ_DATA_W  = 40;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // parameter defaults
   localparam int RESPONSE_DEPTH_DEF = 256;
   localparam int MAX_PIXELS_DEF     = 524288;

   localparam logic [RESULT_W-1:0] RESULT_MAX = '1;

   // request kinds
   typedef logic [KIND_W-1:0] kind_type;
   localparam kind_type KIND_CORRECT  = 2'd0;
   localparam kind_type KIND_UNMAP    = 2'd1;
   localparam kind_type KIND_TABLE_WR = 2'd2;
   localparam kind_type KIND_GAIN_WR  = 2'd3;

   // register indexes
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_MODE     = 2'd0;
   localparam csr_index_type CSR_EXPOSURE = 2'd1;
   localparam csr_index_type CSR_GAIN     = 2'd2;

   // calibration modes
   typedef logic [1:0] mode_type;
   localparam mode_type MODE_GAIN     = 2'd0;
   localparam mode_type MODE_TABLE    = 2'd1;
   localparam mode_type MODE_VIGNETTE = 2'd2;

   // datapath operations carried down the pipeline
   typedef logic [2:0] op_type;
   localparam op_type OP_PLAIN = 3'd0;
   localparam op_type OP_TABLE = 3'd1;
   localparam op_type OP_VIG   = 3'd2;
   localparam op_type OP_UNMAP = 3'd3;
   localparam op_type OP_ZERO  = 3'd4;
   localparam op_type OP_TOP   = 3'd5;

endpackage

/* rtl/core/prvc_ram.sv */
// ----------------------------------------------------------------------------
// prvc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module prvc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/photometric_response_vignette_correct.sv */
// Throughput: one transaction per cycle while rsp_tready does not hold the pipe;
// table and gain writes take effect at acceptance and give no result. The
// pipeline is the registered read of the table and gain memories, one multiply
// stage and one add, shift and saturate stage.
// Reset clears the pipeline valids and sets mode 2, exposure valid, gain 1.0;
// memory contents are undefined until written and are not cleared.
// ----------------------------------------------------------------------------
// photometric_response_vignette_correct
// Response table and per-pixel vignette gain correction, with table unmapping.
// ----------------------------------------------------------------------------
module photometric_response_vignette_correct
   import prvc_pkg::*;
#(
   parameter int RESPONSE_DEPTH = RESPONSE_DEPTH_DEF,
   parameter int MAX_PIXELS     = MAX_PIXELS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // request: tdata = index[18:0], sample[35:19], zero pad; tuser = kind
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic [KIND_W-1:0]      req_tuser,
   // response: tdata = result_value; tuser = saturated
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RESULT_W-1:0]    rsp_tdata,
   output logic                   rsp_tuser,
   // register writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int TBL_AW = $clog2(RESPONSE_DEPTH);
   localparam int VIG_AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int TOP_X  = 256 * RESPONSE_DEPTH - 258;
   localparam logic [RESULT_W-1:0] UNMAP_TOP = RESULT_W'(256 * RESPONSE_DEPTH - 282);

   // configuration
   logic [1:0]         mode_ff,     mode_in;
   logic               exposure_ff, exposure_in;
   logic [ENTRY_W-1:0] gain_ff,     gain_in;

   // handshake
   logic en_out, en2, en1, accept;

   // request fields
   logic [INDEX_W-1:0]  req_index;
   logic [SAMPLE_W-1:0] req_sample;
   logic                sample_pos;
   logic                plain_path;

   // memories
   logic                tbl_wr_en, vig_wr_en;
   logic [TBL_AW-1:0]   tbl_addr_a, tbl_addr_b, code_addr;
   logic [ENTRY_W-1:0]  tbl_a, tbl_b, vig_gain;

   // stage 1
   logic               s1_valid_ff, s1_valid_in;
   op_type             s1_op_ff, s1_op_in;
   logic [ENTRY_W-1:0] s1_code_ff, s1_code_in;
   logic [7:0]         s1_frac_ff, s1_frac_in;
   logic               s1_gain_ok_ff, s1_gain_ok_in;
   logic [ENTRY_W-1:0] mul_x, mul_y;

   // stage 2
   logic               s2_valid_ff, s2_valid_in;
   op_type             s2_op_ff;
   logic [31:0]        s2_m1_ff, s2_m1_in;
   logic [23:0]        s2_m2_ff, s2_m2_in;
   logic [32:0]        sum, shifted;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RESULT_W-1:0] rsp_value_ff, rsp_value_in;
   logic                rsp_sat_ff,   rsp_sat_in;

   // ---------------------------------------------------------------- config
   assign csr_ready = 1'b1;

   always_comb begin
      mode_in     = mode_ff;
      exposure_in = exposure_ff;
      gain_in     = gain_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MODE:     mode_in     = csr_wdata[1:0];
            CSR_EXPOSURE: exposure_in = csr_wdata[0];
            CSR_GAIN:     gain_in     = csr_wdata;
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_VIGNETTE;
         exposure_ff <= 1'b1;
         gain_ff     <= ENTRY_W'(256);
      end else begin
         mode_ff     <= mode_in;
         exposure_ff <= exposure_in;
         gain_ff     <= gain_in;
      end
   end

   // ------------------------------------------------------------- handshake
   // each stage moves when the one after it is empty or moving
   assign en_out     = !rsp_valid_ff || rsp_tready;
   assign en2        = !s2_valid_ff || en_out;
   assign en1        = !s1_valid_ff || en2;
   assign req_tready = en1;
   assign accept     = req_tvalid && en1;

   // --------------------------------------------------------------- stage 0
   assign req_index  = req_tdata[INDEX_W-1:0];
   assign req_sample = req_tdata[INDEX_W +: SAMPLE_W];
   assign sample_pos = !req_sample[SAMPLE_W-1] && (req_sample != '0);
   assign plain_path = (mode_ff == MODE_GAIN) || !exposure_ff;

   always_comb begin
      if (!sample_pos) begin
         code_addr = '0;
      end else if (32'(req_sample[ENTRY_W-1:0]) >= 32'(RESPONSE_DEPTH)) begin
         code_addr = TBL_AW'(RESPONSE_DEPTH - 1);
      end else begin
         code_addr = TBL_AW'(req_sample[ENTRY_W-1:0]);
      end
   end

   // copy a serves the pixel lookup and the lower unmap tap, copy b the upper tap
   assign tbl_addr_a = (req_tuser == KIND_UNMAP) ? TBL_AW'(req_sample[15:8]) : code_addr;
   assign tbl_addr_b = TBL_AW'(req_sample[15:8]) + TBL_AW'(1);
   assign tbl_wr_en  = accept && (req_tuser == KIND_TABLE_WR)
                       && (32'(req_index) < 32'(RESPONSE_DEPTH));
   assign vig_wr_en  = accept && (req_tuser == KIND_GAIN_WR)
                       && (32'(req_index) < 32'(MAX_PIXELS));

   // writes land at acceptance, so a later read always sees them
   prvc_ram #(.WIDTH(ENTRY_W), .DEPTH(RESPONSE_DEPTH)) u_tbl_a (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (TBL_AW'(req_index)),
      .wr_data (req_sample[ENTRY_W-1:0]),
      .rd_en   (accept),
      .rd_addr (tbl_addr_a),
      .rd_data (tbl_a)
   );

   prvc_ram #(.WIDTH(ENTRY_W), .DEPTH(RESPONSE_DEPTH)) u_tbl_b (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (TBL_AW'(req_index)),
      .wr_data (req_sample[ENTRY_W-1:0]),
      .rd_en   (accept),
      .rd_addr (tbl_addr_b),
      .rd_data (tbl_b)
   );

   prvc_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_PIXELS)) u_vig (
      .clock   (clock),
      .wr_en   (vig_wr_en),
      .wr_addr (VIG_AW'(req_index)),
      .wr_data (req_sample[ENTRY_W-1:0]),
      .rd_en   (accept),
      .rd_addr (VIG_AW'(req_index)),
      .rd_data (vig_gain)
   );

   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_op_in      = OP_ZERO;
      s1_code_in    = sample_pos ? req_sample[ENTRY_W-1:0] : '0;
      s1_frac_in    = req_sample[7:0];
      s1_gain_ok_in = 32'(req_index) < 32'(MAX_PIXELS);
      if (accept) begin
         s1_valid_in = (req_tuser == KIND_CORRECT) || (req_tuser == KIND_UNMAP);
      end else if (en2) begin
         s1_valid_in = 1'b0;
      end
      if (req_tuser == KIND_CORRECT) begin
         if (plain_path) begin
            s1_op_in = OP_PLAIN;
         end else if (mode_ff == MODE_VIGNETTE) begin
            s1_op_in = OP_VIG;
         end else begin
            s1_op_in = OP_TABLE;
         end
      end else if (!sample_pos) begin
         s1_op_in = OP_ZERO;
      end else if (32'(req_sample[ENTRY_W-1:0]) >= 32'(TOP_X)) begin
         s1_op_in = OP_TOP;
      end else begin
         s1_op_in = OP_UNMAP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff      <= s1_op_in;
         s1_code_ff    <= s1_code_in;
         s1_frac_ff    <= s1_frac_in;
         s1_gain_ok_ff <= s1_gain_ok_in;
      end
   end

   // --------------------------------------------------------------- stage 1
   // one shared 16x16 multiplier, plus the narrow upper-tap product for unmap
   always_comb begin
      case (s1_op_ff)
         OP_PLAIN: begin
            mul_x = gain_ff;
            mul_y = s1_code_ff;
         end
         OP_TABLE: begin
            mul_x = tbl_a;
            mul_y = ENTRY_W'(1);
         end
         OP_VIG: begin
            mul_x = tbl_a;
            mul_y = s1_gain_ok_ff ? vig_gain : '0;
         end
         OP_UNMAP: begin
            mul_x = tbl_a;
            mul_y = ENTRY_W'(9'd256 - {1'b0, s1_frac_ff});
         end
         default: begin
            mul_x = '0;
            mul_y = '0;
         end
      endcase
   end

   assign s2_m1_in = 32'(mul_x) * 32'(mul_y);
   assign s2_m2_in = (s1_op_ff == OP_UNMAP) ? 24'(tbl_b) * 24'(s1_frac_ff) : '0;

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (en2) begin
         s2_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_op_ff <= s1_op_ff;
         s2_m1_ff <= s2_m1_in;
         s2_m2_ff <= s2_m2_in;
      end
   end

   // --------------------------------------------------------------- stage 2
   assign sum = {1'b0, s2_m1_ff} + 33'(s2_m2_ff);

   always_comb begin
      case (s2_op_ff)
         OP_VIG:   shifted = sum >> 12;
         OP_UNMAP: shifted = sum >> 8;
         OP_TOP:   shifted = 33'(UNMAP_TOP);
         default:  shifted = sum;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (en_out) begin
         rsp_valid_in = s2_valid_ff;
      end
      if (shifted[32:RESULT_W] != '0) begin
         rsp_value_in = RESULT_MAX;
         rsp_sat_in   = 1'b1;
      end else begin
         rsp_value_in = shifted[RESULT_W-1:0];
         rsp_sat_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         rsp_value_ff <= rsp_value_in;
         rsp_sat_ff   <= rsp_sat_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_sat_ff;

endmodule

/* rtl/core/prvc_checker.sv */
// ----------------------------------------------------------------------------
// prvc_checker
// Port-level checks of the photometric correction block, bound to its top.
// ----------------------------------------------------------------------------
module prvc_checker
   import prvc_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic [KIND_W-1:0]   req_tuser,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RESULT_W-1:0] rsp_tdata,
   input logic                rsp_tuser
);

   logic result_accept;

   assign result_accept = req_tvalid && req_tready
                          && ((req_tuser == KIND_CORRECT) || (req_tuser == KIND_UNMAP));

   // a stalled response transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // the saturation flag only comes with the clipped maximum
   a_sat_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == RESULT_MAX)
      else $error("saturated without maximum value");

   // no response straight after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // with the response side ready as the result moves down the pipe, the result reaches rsp_tvalid
   a_latency: assert property (@(posedge clock) disable iff (reset)
      result_accept ##1 rsp_tready ##1 rsp_tready |=> rsp_tvalid)
      else $error("result missing after pipeline latency");

endmodule

bind photometric_response_vignette_correct prvc_checker u_prvc_checker (.*);

/* dv/photometric_response_vignette_correct_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// photometric_response_vignette_correct_test
// Self-checking bench for the photometric correction block. A driver and a
// monitor run on the clock; a predictor mirrors the response table, the
// vignette gains and the registers, and checks each result in order.
// ----------------------------------------------------------------------------
module photometric_response_vignette_correct_test;
   import prvc_pkg::*;

   localparam int LUT_DEPTH  = RESPONSE_DEPTH_DEF;
   localparam int UNMAP_TOP  = LUT_DEPTH * 256 - 258;
   localparam int UNMAP_CEIL = LUT_DEPTH * 256 - 282;
   // mode value with no name of its own, handled as the table mode
   localparam mode_type MODE_RESERVED = 2'd3;

   typedef struct packed {
      kind_type                   kind;
      logic [INDEX_W-1:0]         index;
      logic signed [SAMPLE_W-1:0] sample;
   } pixel_req_type;

   typedef struct packed {
      logic [RESULT_W-1:0] value;
      logic                sat;
   } intensity_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic [KIND_W-1:0]      req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RESULT_W-1:0]    rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   photometric_response_vignette_correct dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor copy of registers and stores
   mode_type               cal_mode = MODE_VIGNETTE;
   logic                   expo_ok = 1'b1;
   logic [CSR_DATA_W-1:0]  plain_gain = 16'h0100;
   logic [ENTRY_W-1:0]     resp_lut [LUT_DEPTH];
   logic [ENTRY_W-1:0]     flat_gain [int];

   // what the stimulus has loaded so far, in queue order
   bit                     lut_loaded [LUT_DEPTH];
   bit                     gain_loaded [int];
   int                     gain_pool [$];

   pixel_req_type          pixel_reqs [$];
   pixel_req_type          req_cur;
   bit                     req_taken = 1'b0;
   intensity_type          intensity_due [$];

   int                     send_idle_pct = 0;
   int                     stall_pct = 0;
   int                     failures = 0;
   int                     n_correct = 0;
   int                     n_unmap = 0;
   int                     n_writes = 0;
   int                     n_checked = 0;
   int                     n_saturated = 0;

   // applies one transaction to the mirrored state; 1 when a result is due
   function automatic bit corrected_intensity(input pixel_req_type r,
                                              output intensity_type res);
      int              s;
      int              addr;
      int              c;
      int              a;
      longint unsigned acc;
      logic [ENTRY_W-1:0] g;
      s = $signed(r.sample);
      acc = 0;
      res = '0;
      case (r.kind)
         KIND_CORRECT: begin
            if (cal_mode == MODE_GAIN || !expo_ok) begin
               if (s > 0)
                  acc = 64'(plain_gain) * 64'(s);
            end else begin
               addr = (s <= 0) ? 0 : ((s >= LUT_DEPTH) ? LUT_DEPTH - 1 : s);
               acc = 64'(resp_lut[addr]);
               if (cal_mode == MODE_VIGNETTE) begin
                  g = flat_gain.exists(int'(r.index)) ? flat_gain[int'(r.index)] : '0;
                  acc = (acc * 64'(g)) >> 12;
               end
            end
         end
         KIND_UNMAP: begin
            if (s <= 0)
               acc = 0;
            else if (s >= UNMAP_TOP)
               acc = 64'(UNMAP_CEIL);
            else begin
               c = s >> 8;
               a = s & 255;
               acc = (64'(resp_lut[c]) * 64'(256 - a) + 64'(resp_lut[c + 1]) * 64'(a)) >> 8;
            end
         end
         KIND_TABLE_WR: begin
            if (r.index < LUT_DEPTH)
               resp_lut[r.index] = r.sample[ENTRY_W-1:0];
            return 1'b0;
         end
         default: begin
            if (r.index < MAX_PIXELS_DEF)
               flat_gain[int'(r.index)] = r.sample[ENTRY_W-1:0];
            return 1'b0;
         end
      endcase
      res.sat = (acc > 64'(RESULT_MAX));
      res.value = res.sat ? RESULT_MAX : acc[RESULT_W-1:0];
      return 1'b1;
   endfunction

   task automatic note_fail(input string msg);
      failures++;
      if (failures <= 10)
         $display("mismatch at %0t: %s", $time, msg);
   endtask

   // driver: valid stays up until the transaction is taken
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pixel_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_cur = pixel_reqs.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= REQ_DATA_W'({req_cur.sample, req_cur.index});
            req_tuser <= req_cur.kind;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // monitor: predict on request acceptance, compare on response acceptance
   always @(posedge clock) begin
      intensity_type due;
      intensity_type got;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_tvalid && req_tready;
         if (req_taken) begin
            case (req_cur.kind)
               KIND_CORRECT: n_correct++;
               KIND_UNMAP:   n_unmap++;
               default:      n_writes++;
            endcase
            if (corrected_intensity(req_cur, due))
               intensity_due.push_back(due);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.value = rsp_tdata;
            got.sat = rsp_tuser;
            n_checked++;
            if (got.sat)
               n_saturated++;
            if (intensity_due.size() == 0) begin
               note_fail($sformatf("result %h sat %b with nothing expected",
                                   got.value, got.sat));
            end else begin
               due = intensity_due.pop_front();
               if (got.value !== due.value || got.sat !== due.sat)
                  note_fail($sformatf("expected %h sat %b, got %h sat %b",
                                      due.value, due.sat, got.value, got.sat));
            end
         end
      end
   end

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_MODE:     cal_mode = data[1:0];
         CSR_EXPOSURE: expo_ok = data[0];
         CSR_GAIN:     plain_gain = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_calibration(input mode_type mode, input logic expo,
                                  input logic [CSR_DATA_W-1:0] gain);
      csr_write(CSR_MODE, CSR_DATA_W'(mode));
      csr_write(CSR_EXPOSURE, CSR_DATA_W'(expo));
      csr_write(CSR_GAIN, gain);
   endtask

   task automatic queue_write(input kind_type kind, input int index,
                              input logic [SAMPLE_W-1:0] sample);
      pixel_req_type r;
      r.kind = kind;
      r.index = INDEX_W'(index);
      r.sample = sample;
      pixel_reqs.push_back(r);
      if (kind == KIND_TABLE_WR && index < LUT_DEPTH) begin
         lut_loaded[index] = 1'b1;
      end else if (kind == KIND_GAIN_WR && !gain_loaded.exists(index)) begin
         gain_loaded[index] = 1'b1;
         gain_pool.push_back(index);
      end
   endtask

   // loads whatever entries the correction will read before issuing it
   task automatic queue_correct(input int pos, input int code);
      pixel_req_type r;
      int            addr;
      addr = (code <= 0) ? 0 : ((code >= LUT_DEPTH) ? LUT_DEPTH - 1 : code);
      if (!lut_loaded[addr])
         queue_write(KIND_TABLE_WR, addr, SAMPLE_W'($urandom));
      if (!gain_loaded.exists(pos))
         queue_write(KIND_GAIN_WR, pos, SAMPLE_W'($urandom));
      r.kind = KIND_CORRECT;
      r.index = INDEX_W'(pos);
      r.sample = SAMPLE_W'(code);
      pixel_reqs.push_back(r);
   endtask

   task automatic queue_unmap(input int x);
      pixel_req_type r;
      int            c;
      if (x > 0 && x < UNMAP_TOP) begin
         c = x >> 8;
         if (!lut_loaded[c])
            queue_write(KIND_TABLE_WR, c, SAMPLE_W'($urandom));
         if (!lut_loaded[c + 1])
            queue_write(KIND_TABLE_WR, c + 1, SAMPLE_W'($urandom));
      end
      r.kind = KIND_UNMAP;
      r.index = INDEX_W'($urandom);
      r.sample = SAMPLE_W'(x);
      pixel_reqs.push_back(r);
   endtask

   task automatic queue_random(input int count);
      int pick;
      int pos;
      int code;
      int x;
      int code_edges [7] = '{-65536, -1, 0, 1, LUT_DEPTH - 1, LUT_DEPTH, 65535};
      int x_edges [10] = '{-65536, -1, 0, 1, 255, 256, UNMAP_TOP - 2, UNMAP_TOP - 1,
                           UNMAP_TOP, 65535};
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            if (gain_pool.size() != 0 && $urandom_range(3) != 0)
               pos = gain_pool[$urandom_range(gain_pool.size() - 1)];
            else
               pos = $urandom_range(MAX_PIXELS_DEF - 1);
            case ($urandom_range(9))
               0:       code = -int'($urandom_range(65536, 1));
               1:       code = $urandom_range(65535, LUT_DEPTH);
               2:       code = code_edges[$urandom_range(6)];
               default: code = $urandom_range(LUT_DEPTH - 1);
            endcase
            queue_correct(pos, code);
         end else if (pick < 70) begin
            case ($urandom_range(9))
               0, 1:    x = int'($urandom_range(131071)) - 65536;
               2:       x = x_edges[$urandom_range(9)];
               default: x = $urandom_range(UNMAP_TOP - 1, 1);
            endcase
            queue_unmap(x);
         end else if (pick < 84) begin
            // a few land beyond the table and are dropped
            queue_write(KIND_TABLE_WR, (pick < 82) ? $urandom_range(LUT_DEPTH - 1)
                                                   : $urandom_range(MAX_PIXELS_DEF - 1),
                        SAMPLE_W'($urandom));
         end else begin
            queue_write(KIND_GAIN_WR, $urandom_range(MAX_PIXELS_DEF - 1), SAMPLE_W'($urandom));
         end
      end
   endtask

   // sender holds off until every result is back, then lets the pipe empty
   task automatic drain();
      while (pixel_reqs.size() != 0 || req_tvalid || intensity_due.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   mode_type              plan_mode [8] = '{MODE_VIGNETTE, MODE_TABLE, MODE_GAIN,
                                            MODE_VIGNETTE, MODE_RESERVED, MODE_VIGNETTE,
                                            MODE_GAIN, MODE_TABLE};
   logic                  plan_expo [8] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
   logic [CSR_DATA_W-1:0] plan_gain [8] = '{16'h0100, 16'h0180, 16'hFFFF, 16'h0000,
                                            16'h0001, 16'h1234, 16'h7FFF, 16'hFFFF};

   initial begin
      logic [CSR_DATA_W-1:0] gain;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // table extremes, dropped writes, unmap corners
      set_calibration(MODE_TABLE, 1'b1, 16'h0100);
      queue_write(KIND_TABLE_WR, 0, 17'h1FFFF);
      queue_write(KIND_TABLE_WR, LUT_DEPTH - 1, 17'h0ABCD);
      queue_write(KIND_TABLE_WR, LUT_DEPTH, 17'h01234);
      queue_write(KIND_TABLE_WR, MAX_PIXELS_DEF - 1, 17'h0FFFF);
      queue_write(KIND_GAIN_WR, MAX_PIXELS_DEF - 1, 17'h01000);
      queue_write(KIND_GAIN_WR, 0, 17'h1FFFF);
      queue_correct(0, -65536);
      queue_correct(0, 0);
      queue_correct(0, 65535);
      queue_unmap(-65536);
      queue_unmap(0);
      queue_unmap(1);
      queue_unmap(256);
      queue_unmap(UNMAP_TOP - 1);
      queue_unmap(UNMAP_TOP);
      queue_unmap(65535);
      drain();
      set_calibration(MODE_VIGNETTE, 1'b1, 16'h0100);
      queue_correct(MAX_PIXELS_DEF - 1, 255);
      queue_correct(0, LUT_DEPTH - 1);
      drain();
      set_calibration(MODE_GAIN, 1'b1, 16'hFFFF);
      queue_correct(0, 65535);
      queue_correct(0, -1);
      queue_correct(0, 256);
      drain();
      set_calibration(MODE_RESERVED, 1'b1, 16'h0000);
      queue_correct(0, 1);
      drain();
      set_calibration(MODE_VIGNETTE, 1'b0, 16'h0000);
      queue_correct(MAX_PIXELS_DEF - 1, 300);
      drain();

      for (int p = 0; p < 8; p++) begin
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 57; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 57; end
            default: begin send_idle_pct = 34; stall_pct = 34; end
         endcase
         gain = (p == 5) ? CSR_DATA_W'($urandom) : plan_gain[p];
         set_calibration(plan_mode[p], plan_expo[p], gain);
         queue_random(58);
         drain();
      end

      if (intensity_due.size() != 0)
         note_fail($sformatf("%0d results never arrived", intensity_due.size()));
      $display("covered %0d pixel corrections, %0d unmaps and %0d table or gain writes",
               n_correct, n_unmap, n_writes);
      $display("checked %0d results, %0d of them clipped, across 13 register settings",
               n_checked, n_saturated);
      if (failures == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d results outstanding", intensity_due.size());
      $display("FAIL");
      $finish;
   end

endmodule
